// File: rtl/ght_pkg.sv
`timescale 1ns / 1ps

package ght_pkg;

   // Table geometry. A handle carries 8 bits of slot index, so at most 256 slots can be addressed.
   localparam int SLOT_COUNT = 256;
   localparam int VALUE_BITS = 64;
   localparam int USABLE     = (SLOT_COUNT < 256) ? SLOT_COUNT : 256;
   localparam int IDX_W      = $clog2(USABLE);

   // Field widths on the ports
   localparam int ACTION_W   = 2;
   localparam int HANDLE_W   = 16;
   localparam int GEN_W      = 8;
   localparam int SLOT_FLD_W = 8;
   localparam int DATA_W     = 64;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 8;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 88;

   // Request actions
   localparam logic [ACTION_W-1:0] ACT_PIN     = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_GET     = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STS_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STS_BAD     = 2'd2;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;   // request taken: launch the slot read
      logic commit;   // apply updates and load the response register
   } cmd_type;

   // Free-list successor of a slot right after reset (last slot ends the list)
   function automatic logic [IDX_W-1:0] reset_next(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] nxt;
      if (int'(idx) == USABLE - 1) begin
         nxt = '0;
      end else begin
         nxt = idx + 1'b1;
      end
      return nxt;
   endfunction

endpackage

// File: rtl/generational_handle_table_unit.sv
`timescale 1ns / 1ps

// Generational handle table with 255 usable slots (slot 0 is reserved, so handle 0 is
// never valid). A pin request (tuser 0) pops the head of the free list, stores the value
// and returns handle {slot, generation}; with no free slot it returns handle 0, status
// full. A get request (tuser 1) returns the stored value for a live handle, otherwise
// the nil value from the CSR and status invalid. A release request (tuser 2) of a live
// handle frees the slot, bumps its generation so old copies go stale, and pushes it on
// the free list. Every request produces exactly one response. Each request is handled in two
// steps: a read of the slot memories at the addressed slot, then a check of the handle and
// a write-back of slot state and the free-list head, which the next request depends on.
// A finished response waits in an output register, so the next request is taken while
// it is pending. No clearing pass is needed after reset. The user writes the nil value
// through the CSR port only while the unit is idle; the unit itself does not enforce it.
module generational_handle_table_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [63:0] csr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // pin_value[63:0], handle_in[79:64]
   input  logic [1:0]  req_tuser,   // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // handle_out[15:0], read_value[79:16], used_count[87:80]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   ght_pkg::cmd_type               cmd;
   logic [ght_pkg::HANDLE_W-1:0]   rsp_handle;
   logic [ght_pkg::DATA_W-1:0]     rsp_value;
   logic [ght_pkg::STATUS_W-1:0]   rsp_status;
   logic [ght_pkg::COUNT_W-1:0]    rsp_count;

   assign csr_ready = 1'b1;

   ght_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   ght_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_action    (req_tuser),
      .req_pin_value (req_tdata[63:0]),
      .req_handle    (req_tdata[79:64]),
      .csr_valid     (csr_valid),
      .csr_data      (csr_data),
      .rsp_handle    (rsp_handle),
      .rsp_value     (rsp_value),
      .rsp_status    (rsp_status),
      .rsp_count     (rsp_count)
   );

   assign rsp_tdata = {rsp_count, rsp_value, rsp_handle};
   assign rsp_tuser = rsp_status;

endmodule

// File: rtl/ght_ctrl.sv
`timescale 1ns / 1ps

module ght_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output ght_pkg::cmd_type  cmd
);

   ght_pkg::state_type state_ff;
   ght_pkg::state_type state_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;

   // Output decode
   always_comb begin
      req_tready = 1'b0;
      cmd.accept = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         ght_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ght_pkg::ST_EXEC: begin
            // wait for the response register to free up
            cmd.commit = !rsp_valid_ff || rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ght_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = ght_pkg::ST_EXEC;
         end
         ght_pkg::ST_EXEC: begin
            if (!rsp_valid_ff || rsp_tready) state_in = ght_pkg::ST_IDLE;
         end
         default: begin
            state_in = ght_pkg::ST_IDLE;
         end
      endcase
   end

   // Response valid flag
   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_tready;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ght_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/ght_dp.sv
`timescale 1ns / 1ps

module ght_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  ght_pkg::cmd_type                   cmd,
   input  logic [ght_pkg::ACTION_W-1:0]       req_action,
   input  logic [ght_pkg::DATA_W-1:0]         req_pin_value,
   input  logic [ght_pkg::HANDLE_W-1:0]       req_handle,
   input  logic                               csr_valid,
   input  logic [ght_pkg::DATA_W-1:0]         csr_data,
   output logic [ght_pkg::HANDLE_W-1:0]       rsp_handle,
   output logic [ght_pkg::DATA_W-1:0]         rsp_value,
   output logic [ght_pkg::STATUS_W-1:0]       rsp_status,
   output logic [ght_pkg::COUNT_W-1:0]        rsp_count
);

   localparam int IW = ght_pkg::IDX_W;
   localparam int GW = ght_pkg::GEN_W;
   localparam int VW = ght_pkg::VALUE_BITS;
   localparam int US = ght_pkg::USABLE;

   // Slot memories: value store and {generation, free-list next}
   logic [VW-1:0]      value_mem [US];
   logic [GW+IW-1:0]   meta_mem  [US];
   logic [US-1:0]      meta_written_ff;
   logic [US-1:0]      in_use_ff;

   logic [VW-1:0]      nil_ff;
   logic [IW-1:0]      free_head_ff;
   logic [IW-1:0]      free_head_in;
   logic [ght_pkg::COUNT_W-1:0] total_ff;
   logic [ght_pkg::COUNT_W-1:0] total_in;

   // Request captured at accept
   logic [ght_pkg::ACTION_W-1:0] act_ff;
   logic [VW-1:0]      pin_ff;
   logic [GW-1:0]      hgen_ff;
   logic               hidx_ok_ff;
   logic [IW-1:0]      addr_ff;
   logic [VW-1:0]      value_rd_ff;
   logic [GW+IW-1:0]   meta_rd_ff;
   logic               meta_seen_ff;
   logic               in_use_rd_ff;

   // Address decode for the single read
   logic [ght_pkg::SLOT_FLD_W-1:0] hidx;
   logic               hidx_ok;
   logic [IW-1:0]      rd_addr;

   assign hidx    = req_handle[ght_pkg::HANDLE_W-1:GW];
   assign hidx_ok = (hidx != '0) && ({1'b0, hidx} < 9'(US));
   assign rd_addr = (req_action == ght_pkg::ACT_PIN) ? free_head_ff : hidx[IW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         act_ff       <= req_action;
         pin_ff       <= req_pin_value[VW-1:0];
         hgen_ff      <= req_handle[GW-1:0];
         hidx_ok_ff   <= hidx_ok;
         addr_ff      <= rd_addr;
         value_rd_ff  <= value_mem[rd_addr];
         meta_rd_ff   <= meta_mem[rd_addr];
         meta_seen_ff <= meta_written_ff[rd_addr];
         in_use_rd_ff <= in_use_ff[rd_addr];
      end
   end

   // Slot metadata, falling back to reset contents for never-written entries
   logic [GW-1:0] slot_gen;
   logic [IW-1:0] slot_next;
   logic          live;
   logic          pin_ok;
   logic          rel_ok;
   logic          get_ok;

   assign slot_gen  = meta_seen_ff ? meta_rd_ff[GW+IW-1:IW] : '0;
   assign slot_next = meta_seen_ff ? meta_rd_ff[IW-1:0] : ght_pkg::reset_next(addr_ff);
   assign live      = hidx_ok_ff && in_use_rd_ff && (slot_gen == hgen_ff);
   assign pin_ok    = (act_ff == ght_pkg::ACT_PIN) && (free_head_ff != '0);
   assign get_ok    = (act_ff == ght_pkg::ACT_GET) && live;
   assign rel_ok    = (act_ff == ght_pkg::ACT_RELEASE) && live;

   // Head pointer and occupancy updates
   always_comb begin
      free_head_in = free_head_ff;
      total_in     = total_ff;
      if (pin_ok) begin
         free_head_in = slot_next;
         total_in     = total_ff + 1'b1;
      end else if (rel_ok) begin
         free_head_in = addr_ff;
         if (total_ff != '0) total_in = total_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff    <= IW'(1);
         total_ff        <= '0;
         in_use_ff       <= '0;
         meta_written_ff <= '0;
         nil_ff          <= '0;
      end else begin
         if (csr_valid) nil_ff <= csr_data[VW-1:0];
         if (cmd.commit) begin
            free_head_ff <= free_head_in;
            total_ff     <= total_in;
            if (pin_ok) in_use_ff[addr_ff] <= 1'b1;
            if (rel_ok) begin
               in_use_ff[addr_ff]       <= 1'b0;
               meta_written_ff[addr_ff] <= 1'b1;
            end
         end
      end
   end

   // Memory write port
   always_ff @(posedge clock) begin
      if (cmd.commit && pin_ok) value_mem[addr_ff] <= pin_ff;
      if (cmd.commit && rel_ok) meta_mem[addr_ff] <= {slot_gen + 1'b1, free_head_ff};
   end

   // Response register
   logic [ght_pkg::HANDLE_W-1:0] handle_res;
   logic [VW-1:0]                value_res;
   logic [ght_pkg::STATUS_W-1:0] status_res;

   always_comb begin
      handle_res = '0;
      value_res  = nil_ff;
      status_res = ght_pkg::STS_BAD;
      unique case (act_ff)
         ght_pkg::ACT_PIN: begin
            if (pin_ok) begin
               handle_res = {ght_pkg::SLOT_FLD_W'(addr_ff), slot_gen};
               status_res = ght_pkg::STS_OK;
            end else begin
               status_res = ght_pkg::STS_FULL;
            end
         end
         ght_pkg::ACT_GET: begin
            if (get_ok) begin
               value_res  = value_rd_ff;
               status_res = ght_pkg::STS_OK;
            end
         end
         ght_pkg::ACT_RELEASE: begin
            if (rel_ok) status_res = ght_pkg::STS_OK;
         end
         default: begin
            status_res = ght_pkg::STS_BAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_handle <= handle_res;
         rsp_value  <= ght_pkg::DATA_W'(value_res);
         rsp_status <= status_res;
         rsp_count  <= total_in;
      end
   end

endmodule

// File: dv/generational_handle_table_unit_tb.sv
`timescale 1ns / 1ps

// One response as seen on the rsp channel, fields unpacked
typedef struct {
   logic [ght_pkg::HANDLE_W-1:0] handle;
   logic [ght_pkg::DATA_W-1:0]   value;
   logic [ght_pkg::STATUS_W-1:0] status;
   logic [ght_pkg::COUNT_W-1:0]  used;
} table_reply_type;

// Shadow copy of the handle table plus the queue of replies still owed by the unit
class handle_table_board;
   logic [ght_pkg::DATA_W-1:0]  slot_value [ght_pkg::USABLE];
   logic [ght_pkg::GEN_W-1:0]   slot_gen [ght_pkg::USABLE];
   bit                          slot_live [ght_pkg::USABLE];
   int unsigned                 free_link [ght_pkg::USABLE];
   int unsigned                 free_head;
   logic [ght_pkg::COUNT_W-1:0] live_count;
   logic [ght_pkg::DATA_W-1:0]  nil_value;
   table_reply_type             owed_replies[$];
   int                          mismatches;
   int                          replies_seen;
   int                          full_hits;
   int                          bad_hits;
   int                          gets_ok;

   function new();
      for (int i = 0; i < ght_pkg::USABLE; i++) begin
         slot_value[i] = '0;
         slot_gen[i]   = '0;
         slot_live[i]  = 1'b0;
         free_link[i]  = (i + 1 < ght_pkg::USABLE) ? i + 1 : 0;
      end
      free_head    = 1;
      live_count   = '0;
      nil_value    = '0;
      mismatches   = 0;
      replies_seen = 0;
      full_hits    = 0;
      bad_hits     = 0;
      gets_ok      = 0;
   endfunction

   // Slot 0 is reserved; index, in-use mark and generation must all agree
   function bit handle_is_live(logic [ght_pkg::HANDLE_W-1:0] h, output int unsigned slot);
      slot = h[15:8];
      if (slot == 0 || slot >= ght_pkg::USABLE) return 1'b0;
      return slot_live[slot] && (slot_gen[slot] == h[7:0]);
   endfunction

   // Apply one accepted request to the shadow table and queue the reply it owes
   function table_reply_type note_request(logic [ght_pkg::ACTION_W-1:0] action,
                                          logic [ght_pkg::DATA_W-1:0] pin_value,
                                          logic [ght_pkg::HANDLE_W-1:0] handle_in);
      table_reply_type r;
      int unsigned     slot;
      r.handle = '0;
      r.value  = nil_value;
      r.status = ght_pkg::STS_BAD;
      case (action)
         ght_pkg::ACT_PIN: begin
            if (free_head == 0 || free_head >= ght_pkg::USABLE) begin
               r.status = ght_pkg::STS_FULL;
            end else begin
               slot            = free_head;
               free_head       = free_link[slot];
               free_link[slot] = 0;
               slot_value[slot] = pin_value;
               slot_live[slot]  = 1'b1;
               live_count++;
               r.handle = {8'(slot), slot_gen[slot]};
               r.status = ght_pkg::STS_OK;
            end
         end
         ght_pkg::ACT_GET: begin
            if (handle_is_live(handle_in, slot)) begin
               r.value  = slot_value[slot];
               r.status = ght_pkg::STS_OK;
               gets_ok++;
            end
         end
         ght_pkg::ACT_RELEASE: begin
            if (handle_is_live(handle_in, slot)) begin
               slot_value[slot] = '0;
               slot_live[slot]  = 1'b0;
               slot_gen[slot]   = slot_gen[slot] + 1'b1;
               free_link[slot]  = free_head;
               free_head        = slot;
               if (live_count != 0) live_count--;
               r.status = ght_pkg::STS_OK;
            end
         end
         default: ;
      endcase
      if (r.status == ght_pkg::STS_FULL) full_hits++;
      if (r.status == ght_pkg::STS_BAD) bad_hits++;
      r.used = live_count;
      owed_replies.push_back(r);
      return r;
   endfunction

   task report(string what, logic [63:0] got, logic [63:0] want);
      if (mismatches < 40) begin
         $display("mismatch on %s at %0t: got %h, expected %h", what, $realtime, got, want);
      end
      mismatches++;
   endtask

   // Compare one accepted response against the oldest owed reply
   task check_response(logic [ght_pkg::RSP_DATA_W-1:0] data,
                       logic [ght_pkg::STATUS_W-1:0] st);
      table_reply_type want;
      if (owed_replies.size() == 0) begin
         report("unexpected response", data[63:0], '0);
         return;
      end
      want = owed_replies.pop_front();
      replies_seen++;
      if (data[15:0] !== want.handle) report("handle_out", data[15:0], want.handle);
      if (data[79:16] !== want.value) report("read_value", data[79:16], want.value);
      if (st !== want.status) report("status", st, want.status);
      if (data[87:80] !== want.used) report("used_count", data[87:80], want.used);
   endtask
endclass

module generational_handle_table_unit_tb;

   localparam logic [ght_pkg::ACTION_W-1:0] ACT_UNKNOWN  = 2'd3;
   localparam int                           STALL_CYCLES = 300;
   localparam int                           WATCHDOG_MAX = 4000;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [63:0]                    csr_data = '0;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   // pin_value[63:0], handle_in[79:64]
   logic [ght_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]                     req_tuser = '0;   // action[1:0]
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   // handle_out[15:0], read_value[79:16], used_count[87:80]
   logic [ght_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]                     rsp_tuser;       // status[1:0]

   handle_table_board            board;
   logic [ght_pkg::HANDLE_W-1:0] live_handles[$];
   logic [ght_pkg::HANDLE_W-1:0] old_handles[$];
   table_reply_type              last_reply;
   bit                           quiet = 1'b0;
   bit                           hold_request = 1'b0;
   int                           idle_cycles = 0;
   int                           nil_writes = 0;

   generational_handle_table_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   // Mostly random values, with the all-zero and all-one extremes mixed in
   function automatic logic [ght_pkg::DATA_W-1:0] pick_value();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Offer one request, idling first at random, and record it once taken
   task automatic send_request(logic [ght_pkg::ACTION_W-1:0] action,
                               logic [ght_pkg::DATA_W-1:0] value,
                               logic [ght_pkg::HANDLE_W-1:0] handle);
      if (!quiet && $urandom_range(99) < 24) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 24);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {handle, value};
      req_tuser  <= action;
      do @(posedge clock); while (!req_tready);
      last_reply = board.note_request(action, value, handle);
      if (action == ght_pkg::ACT_PIN && last_reply.status == ght_pkg::STS_OK) begin
         live_handles.push_back(last_reply.handle);
      end
   endtask

   // Let every owed response come back, then let the unit settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (board.owed_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_nil(logic [63:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.nil_value = value;
      nil_writes++;
   endtask

   // One random request: pins, gets and releases of live handles, stale handles, noise
   task automatic random_item(int pin_pct, int rel_pct);
      int                           r;
      int                           k;
      logic [ght_pkg::HANDLE_W-1:0] h;
      r = $urandom_range(99);
      if (r < pin_pct) begin
         send_request(ght_pkg::ACT_PIN, pick_value(), 16'($urandom));
      end else if (r < pin_pct + rel_pct && live_handles.size() != 0) begin
         k = $urandom_range(live_handles.size() - 1);
         h = live_handles[k];
         live_handles.delete(k);
         old_handles.push_back(h);
         if (old_handles.size() > 64) void'(old_handles.pop_front());
         send_request(ght_pkg::ACT_RELEASE, pick_value(), h);
      end else if (r < 90 && live_handles.size() != 0) begin
         send_request(ght_pkg::ACT_GET, pick_value(),
                      live_handles[$urandom_range(live_handles.size() - 1)]);
      end else if (r < 95 && old_handles.size() != 0) begin
         send_request(ght_pkg::ACT_GET + ght_pkg::ACTION_W'($urandom_range(1)), pick_value(),
                      old_handles[$urandom_range(old_handles.size() - 1)]);
      end else begin
         h = 16'($urandom);
         // near miss: a live slot with a wrong generation
         if (live_handles.size() != 0 && $urandom_range(1) == 0) begin
            h = live_handles[$urandom_range(live_handles.size() - 1)]
                ^ {8'h00, 8'($urandom_range(1, 255))};
         end
         send_request(ght_pkg::ACTION_W'($urandom_range(3)), pick_value(), h);
      end
   endtask

   // Response side: check accepted responses, stall at random or for a long hold-off
   initial begin : response_sink
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) board.check_response(rsp_tdata, rsp_tuser);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = STALL_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet || ($urandom_range(99) >= 24);
         end
      end
   end

   // Watchdog: too long without any handshake ends the run
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_MAX) begin
         $display("watchdog: no handshake for %0d cycles", WATCHDOG_MAX);
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [ght_pkg::HANDLE_W-1:0] h1, h2, h3, h4, h;
      board = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, nil value still at its reset value
      send_request(ght_pkg::ACT_PIN, '0, 16'h0000);
      h1 = last_reply.handle;
      send_request(ght_pkg::ACT_PIN, '1, 16'hFFFF);
      h2 = last_reply.handle;
      send_request(ght_pkg::ACT_PIN, 64'h5555_5555_5555_5555, 16'h0101);
      h3 = last_reply.handle;
      send_request(ght_pkg::ACT_GET, '0, h1);
      send_request(ght_pkg::ACT_GET, '1, h2);
      send_request(ght_pkg::ACT_GET, '0, 16'h0000);          // reserved slot
      send_request(ght_pkg::ACT_GET, '0, 16'h00FF);
      send_request(ght_pkg::ACT_GET, '0, 16'hFF00);          // top slot, never pinned
      send_request(ght_pkg::ACT_GET, '0, h1 ^ 16'h0080);     // wrong generation
      send_request(ght_pkg::ACT_RELEASE, '0, h2);
      send_request(ght_pkg::ACT_GET, '0, h2);                // stale now
      send_request(ght_pkg::ACT_RELEASE, '1, h2);            // double release
      // reuses freed slot
      send_request(ght_pkg::ACT_PIN, 64'hAAAA_AAAA_AAAA_AAAA, 16'h0000);
      h4 = last_reply.handle;
      send_request(ght_pkg::ACT_GET, '0, h4);
      send_request(ACT_UNKNOWN, '1, h4);
      send_request(ACT_UNKNOWN, '0, 16'hFFFF);
      send_request(ght_pkg::ACT_RELEASE, '0, 16'hFFFF);
      send_request(ght_pkg::ACT_RELEASE, '0, h1);
      send_request(ght_pkg::ACT_RELEASE, '0, h3);
      send_request(ght_pkg::ACT_RELEASE, '0, h4);
      send_request(ght_pkg::ACT_GET, '0, h4);
      send_request(ght_pkg::ACT_GET, '0, h1);
      live_handles.delete();
      old_handles = '{h1, h2, h3, h4};

      // Balanced traffic, with a stretch of no idling on either side
      program_nil('1);
      for (int n = 0; n < 250; n++) begin
         quiet = (n >= 80 && n < 200);
         random_item(40, 25);
      end
      quiet = 1'b0;

      // Fill past full while the response side holds off for a long stretch
      program_nil({$urandom, $urandom});
      hold_request = 1'b1;
      for (int n = 0; n < 300; n++) random_item(85, 3);

      // Drain most of the table
      program_nil('0);
      for (int n = 0; n < 250; n++) random_item(10, 75);

      // Pin and release in pairs so one slot cycles its generation past wraparound
      program_nil(64'h8000_0000_0000_0001);
      for (int n = 0; n < 258; n++) begin
         send_request(ght_pkg::ACT_PIN, pick_value(), 16'($urandom));
         if (last_reply.status == ght_pkg::STS_OK) begin
            h = last_reply.handle;
            void'(live_handles.pop_back());
            if ($urandom_range(3) == 0) send_request(ght_pkg::ACT_GET, pick_value(), h);
            send_request(ght_pkg::ACT_RELEASE, pick_value(), h);
            if ($urandom_range(7) == 0) send_request(ght_pkg::ACT_GET, pick_value(), h);
         end
      end

      // Mixed tail
      program_nil({$urandom, $urandom});
      for (int n = 0; n < 100; n++) random_item(35, 30);

      wait_idle();
      repeat (10) @(posedge clock);
      $display("covered %0d requests: %0d pins refused on a full table, %0d bad handles,",
               board.replies_seen, board.full_hits, board.bad_hits);
      $display("%0d good gets, nil value reprogrammed %0d times, %0d mismatches",
               board.gets_ok, nil_writes, board.mismatches);
      if (board.mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
